FILE: hdl/assert_macros.svh
// assertion macros used by the list engine core
// expects clk and rst in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ORLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define ORLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/orle_pkg.sv
// shared types and constants for the ordered record list engine
// no dependencies
package orle_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int KEY_WIDTH_DEF = 16;
  localparam int SCORE_W       = 7;
  localparam int POS_W         = 5;
  localparam int COUNT_W       = 6;
  localparam int RESULT_LIMIT  = 32;

  typedef enum logic [3:0] {
    OP_INS_HEAD  = 4'd0,
    OP_INS_TAIL  = 4'd1,
    OP_INS_AFTER = 4'd2,
    OP_DEL_HEAD  = 4'd3,
    OP_DEL_AFTER = 4'd4,
    OP_DEL_KEY   = 4'd5,
    OP_SEARCH    = 4'd6,
    OP_SORT_ASC  = 4'd7,
    OP_SORT_DESC = 4'd8,
    OP_LIST      = 4'd9,
    OP_FILTER    = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MISSING = 3'd3,
    ST_BADPOS  = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RD, S_INS_WR, S_PUT,
    S_DEL_RD, S_DEL_CAP, S_TAKE, S_TAKE_WR,
    S_FIND_RD, S_FIND_CHK,
    S_SA_I, S_SA_IC, S_SA_J, S_SA_JC, S_SA_W1, S_SA_W2,
    S_SD_I, S_SD_IC, S_SD_J, S_SD_JC, S_SD_W,
    S_LS_RD, S_LS_CHK
  } state_t;

endpackage

FILE: hdl/orle_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module orle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ordered_record_list_engine_core.sv
// ordered record list engine: packed list of key/score records in one ram
// depends on orle_pkg, orle_ram and assert_macros.svh
//
//  channel | handshake      | fields
//  --------+----------------+-----------------------------------------------
//  command | start / busy   | operation key score position min_score
//  result  | strobe         | out_key out_score out_position status
//          |                | entry_count last
//
// every ram read is registered (address, then registered data)
// inserts and deletes shift the records behind the spot
// search and listing walk the list, sorts rescan it on each pass
// checks that fail give their single result in the cycle after the command
// rst is synchronous; the ram content is not cleared, entries past the count
// are never used; results cannot be stalled, one strobe per beat
`include "assert_macros.svh"

module ordered_record_list_engine_core #(
  parameter int CAPACITY  = orle_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = orle_pkg::KEY_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   operation,
  input  logic [KEY_WIDTH-1:0]         key,
  input  logic [orle_pkg::SCORE_W-1:0] score,
  input  logic [orle_pkg::POS_W-1:0]   position,
  input  logic [orle_pkg::SCORE_W-1:0] min_score,
  output logic                         strobe,
  output logic [KEY_WIDTH-1:0]         out_key,
  output logic [orle_pkg::SCORE_W-1:0] out_score,
  output logic [orle_pkg::POS_W-1:0]   out_position,
  output logic [2:0]                   status,
  output logic [orle_pkg::COUNT_W-1:0] entry_count,
  output logic                         last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = ((CNT_W > orle_pkg::POS_W) ? CNT_W : orle_pkg::POS_W) + 1;
  localparam int SW    = orle_pkg::SCORE_W;
  localparam int REC_W = KEY_WIDTH + SW;

  orle_pkg::state_t st, st_next;
  orle_pkg::op_t    op_r, op_r_next;

  logic [KEY_WIDTH-1:0] key_r, key_r_next;
  logic [SW-1:0]        score_r, score_r_next;
  logic [SW-1:0]        thr_r, thr_r_next;
  logic [CNT_W-1:0]     total, total_next;
  logic [CNT_W-1:0]     idx, idx_next;
  logic [CNT_W-1:0]     jdx, jdx_next;
  logic [CNT_W-1:0]     sel, sel_next;
  logic [REC_W-1:0]     hold, hold_next;
  logic [REC_W-1:0]     mrec, mrec_next;
  logic                 pend, pend_next;
  logic [orle_pkg::COUNT_W-1:0] kcnt, kcnt_next;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [REC_W-1:0] wdata, rdata;

  logic                   em_vld, em_last;
  logic [KEY_WIDTH-1:0]   em_key;
  logic [SW-1:0]          em_score;
  logic [CNT_W-1:0]       em_pos, em_cnt;
  orle_pkg::status_t      em_st;

  logic [PW-1:0]    pos_p1, n_ext;
  logic [KEY_WIDTH-1:0] rkey;
  logic [SW-1:0]        rscore;

  assign pos_p1 = PW'(position) + PW'(1);
  assign n_ext  = PW'(total);
  assign rkey   = rdata[REC_W-1:SW];
  assign rscore = rdata[SW-1:0];
  assign busy   = (st != orle_pkg::S_IDLE);

  orle_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= orle_pkg::S_IDLE;
      total  <= '0;
      strobe <= 1'b0;
    end else begin
      st     <= st_next;
      total  <= total_next;
      strobe <= em_vld;
    end
    op_r    <= op_r_next;
    key_r   <= key_r_next;
    score_r <= score_r_next;
    thr_r   <= thr_r_next;
    idx     <= idx_next;
    jdx     <= jdx_next;
    sel     <= sel_next;
    hold    <= hold_next;
    mrec    <= mrec_next;
    pend    <= pend_next;
    kcnt    <= kcnt_next;
    if (em_vld) begin
      out_key      <= em_key;
      out_score    <= em_score;
      out_position <= orle_pkg::POS_W'(em_pos);
      status       <= em_st;
      entry_count  <= orle_pkg::COUNT_W'(em_cnt);
      last         <= em_last;
    end
  end

  always_comb begin
    st_next      = st;
    op_r_next    = op_r;
    key_r_next   = key_r;
    score_r_next = score_r;
    thr_r_next   = thr_r;
    total_next   = total;
    idx_next     = idx;
    jdx_next     = jdx;
    sel_next     = sel;
    hold_next    = hold;
    mrec_next    = mrec;
    pend_next    = pend;
    kcnt_next    = kcnt;
    we           = 1'b0;
    waddr        = idx[IDX_W-1:0];
    wdata        = rdata;
    raddr        = jdx[IDX_W-1:0];
    em_vld       = 1'b0;
    em_last      = 1'b1;
    em_key       = '0;
    em_score     = '0;
    em_pos       = '0;
    em_st        = orle_pkg::ST_OK;
    em_cnt       = total;

    unique case (st)
      orle_pkg::S_IDLE: begin
        if (start) begin
          op_r_next    = orle_pkg::op_t'(operation);
          key_r_next   = key;
          score_r_next = score;
          thr_r_next   = min_score;
          jdx_next     = '0;
          kcnt_next    = '0;
          pend_next    = 1'b0;
          unique case (orle_pkg::op_t'(operation))
            orle_pkg::OP_INS_HEAD, orle_pkg::OP_INS_TAIL: begin
              if (total >= CNT_W'(CAPACITY)) begin
                em_vld = 1'b1;
                em_st  = orle_pkg::ST_FULL;
              end else begin
                idx_next = (orle_pkg::op_t'(operation) == orle_pkg::OP_INS_HEAD) ? '0 : total;
                jdx_next = total;
                st_next  = (orle_pkg::op_t'(operation) == orle_pkg::OP_INS_HEAD && total != '0)
                           ? orle_pkg::S_INS_RD : orle_pkg::S_PUT;
              end
            end
            orle_pkg::OP_INS_AFTER: begin
              em_vld = 1'b1;
              if (total >= CNT_W'(CAPACITY)) begin
                em_st = orle_pkg::ST_FULL;
              end else if (total == '0) begin
                em_st = orle_pkg::ST_EMPTY;
              end else if (PW'(position) >= n_ext) begin
                em_st = orle_pkg::ST_BADPOS;
              end else begin
                em_vld   = 1'b0;
                idx_next = CNT_W'(pos_p1);
                jdx_next = total;
                st_next  = (pos_p1 < n_ext) ? orle_pkg::S_INS_RD : orle_pkg::S_PUT;
              end
            end
            orle_pkg::OP_DEL_HEAD, orle_pkg::OP_DEL_AFTER: begin
              em_vld = 1'b1;
              if (total == '0) begin
                em_st = orle_pkg::ST_EMPTY;
              end else if (orle_pkg::op_t'(operation) == orle_pkg::OP_DEL_HEAD) begin
                em_vld   = 1'b0;
                idx_next = '0;
                st_next  = orle_pkg::S_DEL_RD;
              end else if (pos_p1 >= n_ext) begin
                em_st = orle_pkg::ST_BADPOS;
              end else begin
                em_vld   = 1'b0;
                idx_next = CNT_W'(pos_p1);
                st_next  = orle_pkg::S_DEL_RD;
              end
            end
            orle_pkg::OP_DEL_KEY, orle_pkg::OP_SEARCH, orle_pkg::OP_LIST,
            orle_pkg::OP_FILTER: begin
              if (total == '0) begin
                em_vld = 1'b1;
                em_st  = orle_pkg::ST_EMPTY;
              end else begin
                st_next = (orle_pkg::op_t'(operation) == orle_pkg::OP_DEL_KEY ||
                           orle_pkg::op_t'(operation) == orle_pkg::OP_SEARCH)
                          ? orle_pkg::S_FIND_RD : orle_pkg::S_LS_RD;
              end
            end
            orle_pkg::OP_SORT_ASC, orle_pkg::OP_SORT_DESC: begin
              idx_next = '0;
              if (total < CNT_W'(2)) begin
                em_vld = 1'b1;
              end else begin
                st_next = (orle_pkg::op_t'(operation) == orle_pkg::OP_SORT_ASC)
                          ? orle_pkg::S_SA_I : orle_pkg::S_SD_I;
              end
            end
            default: em_vld = 1'b1;
          endcase
        end
      end

      // shift records up one place, from the tail down to the new spot
      orle_pkg::S_INS_RD: begin
        raddr   = IDX_W'(jdx - CNT_W'(1));
        st_next = orle_pkg::S_INS_WR;
      end
      orle_pkg::S_INS_WR: begin
        we       = 1'b1;
        waddr    = jdx[IDX_W-1:0];
        jdx_next = jdx - CNT_W'(1);
        st_next  = (jdx - CNT_W'(1) > idx) ? orle_pkg::S_INS_RD : orle_pkg::S_PUT;
      end
      orle_pkg::S_PUT: begin
        we         = 1'b1;
        wdata      = {key_r, score_r};
        total_next = total + CNT_W'(1);
        em_vld     = 1'b1;
        em_key     = key_r;
        em_score   = score_r;
        em_pos     = idx;
        em_cnt     = total + CNT_W'(1);
        st_next    = orle_pkg::S_IDLE;
      end

      orle_pkg::S_DEL_RD: begin
        raddr   = idx[IDX_W-1:0];
        st_next = orle_pkg::S_DEL_CAP;
      end
      orle_pkg::S_DEL_CAP: begin
        hold_next = rdata;
        jdx_next  = idx;
        st_next   = orle_pkg::S_TAKE;
      end
      // close the gap: move each later record down one place
      orle_pkg::S_TAKE: begin
        raddr = IDX_W'(jdx + CNT_W'(1));
        if (jdx + CNT_W'(1) < total) begin
          st_next = orle_pkg::S_TAKE_WR;
        end else begin
          total_next = total - CNT_W'(1);
          em_vld     = 1'b1;
          em_key     = hold[REC_W-1:SW];
          em_score   = hold[SW-1:0];
          em_pos     = idx;
          em_cnt     = total - CNT_W'(1);
          st_next    = orle_pkg::S_IDLE;
        end
      end
      orle_pkg::S_TAKE_WR: begin
        we       = 1'b1;
        waddr    = jdx[IDX_W-1:0];
        jdx_next = jdx + CNT_W'(1);
        st_next  = orle_pkg::S_TAKE;
      end

      orle_pkg::S_FIND_RD: begin
        if (jdx < total) begin
          st_next = orle_pkg::S_FIND_CHK;
        end else begin
          em_vld  = 1'b1;
          em_st   = orle_pkg::ST_MISSING;
          st_next = orle_pkg::S_IDLE;
        end
      end
      orle_pkg::S_FIND_CHK: begin
        if (rkey == key_r) begin
          hold_next = rdata;
          idx_next  = jdx;
          if (op_r == orle_pkg::OP_SEARCH) begin
            em_vld   = 1'b1;
            em_key   = rkey;
            em_score = rscore;
            em_pos   = jdx;
            st_next  = orle_pkg::S_IDLE;
          end else begin
            st_next = orle_pkg::S_TAKE;
          end
        end else begin
          jdx_next = jdx + CNT_W'(1);
          st_next  = orle_pkg::S_FIND_RD;
        end
      end

      // selection sort: idx is the pass, jdx the scan, sel the smallest so far
      orle_pkg::S_SA_I: begin
        raddr   = idx[IDX_W-1:0];
        st_next = orle_pkg::S_SA_IC;
      end
      orle_pkg::S_SA_IC: begin
        hold_next = rdata;
        mrec_next = rdata;
        sel_next  = idx;
        jdx_next  = idx + CNT_W'(1);
        st_next   = orle_pkg::S_SA_J;
      end
      orle_pkg::S_SA_J: begin
        st_next = orle_pkg::S_SA_JC;
      end
      orle_pkg::S_SA_JC: begin
        if (rkey < mrec[REC_W-1:SW]) begin
          mrec_next = rdata;
          sel_next  = jdx;
        end
        jdx_next = jdx + CNT_W'(1);
        st_next  = (jdx + CNT_W'(1) < total) ? orle_pkg::S_SA_J : orle_pkg::S_SA_W1;
      end
      orle_pkg::S_SA_W1: begin
        we      = (sel != idx);
        wdata   = mrec;
        st_next = orle_pkg::S_SA_W2;
      end
      orle_pkg::S_SA_W2: begin
        we       = (sel != idx);
        waddr    = sel[IDX_W-1:0];
        wdata    = hold;
        idx_next = idx + CNT_W'(1);
        if (idx + CNT_W'(2) < total) begin
          st_next = orle_pkg::S_SA_I;
        end else begin
          em_vld  = 1'b1;
          st_next = orle_pkg::S_IDLE;
        end
      end

      // exchange sort: hold carries what position idx holds during the scan
      orle_pkg::S_SD_I: begin
        raddr   = idx[IDX_W-1:0];
        st_next = orle_pkg::S_SD_IC;
      end
      orle_pkg::S_SD_IC: begin
        hold_next = rdata;
        jdx_next  = idx + CNT_W'(1);
        st_next   = orle_pkg::S_SD_J;
      end
      orle_pkg::S_SD_J: begin
        st_next = orle_pkg::S_SD_JC;
      end
      orle_pkg::S_SD_JC: begin
        if (hold[REC_W-1:SW] < rkey) begin
          we        = 1'b1;
          waddr     = jdx[IDX_W-1:0];
          wdata     = hold;
          hold_next = rdata;
        end
        jdx_next = jdx + CNT_W'(1);
        st_next  = (jdx + CNT_W'(1) < total) ? orle_pkg::S_SD_J : orle_pkg::S_SD_W;
      end
      orle_pkg::S_SD_W: begin
        we       = 1'b1;
        wdata    = hold;
        idx_next = idx + CNT_W'(1);
        if (idx + CNT_W'(2) < total) begin
          st_next = orle_pkg::S_SD_I;
        end else begin
          em_vld  = 1'b1;
          st_next = orle_pkg::S_IDLE;
        end
      end

      // one match is held back so the final beat can carry last
      orle_pkg::S_LS_RD: begin
        if (jdx < total && kcnt < orle_pkg::COUNT_W'(orle_pkg::RESULT_LIMIT)) begin
          st_next = orle_pkg::S_LS_CHK;
        end else begin
          em_vld   = 1'b1;
          em_key   = hold[REC_W-1:SW];
          em_score = hold[SW-1:0];
          em_pos   = idx;
          if (!pend) begin
            em_key   = '0;
            em_score = '0;
            em_pos   = '0;
            em_st    = orle_pkg::ST_MISSING;
          end
          st_next = orle_pkg::S_IDLE;
        end
      end
      orle_pkg::S_LS_CHK: begin
        if (op_r == orle_pkg::OP_LIST || rscore >= thr_r) begin
          em_vld    = pend;
          em_last   = 1'b0;
          em_key    = hold[REC_W-1:SW];
          em_score  = hold[SW-1:0];
          em_pos    = idx;
          hold_next = rdata;
          idx_next  = jdx;
          pend_next = 1'b1;
          kcnt_next = kcnt + orle_pkg::COUNT_W'(1);
        end
        jdx_next = jdx + CNT_W'(1);
        st_next  = orle_pkg::S_LS_RD;
      end

      default: st_next = orle_pkg::S_IDLE;
    endcase
  end

  `ORLE_ASSERT_SAME(a_total_bound, 1'b1, total <= CNT_W'(CAPACITY), "record count past capacity")
  `ORLE_ASSERT_SAME(a_fail_zero, strobe && status != orle_pkg::ST_OK,
    out_key == '0 && out_position == '0, "failed beat carries a record")
  `ORLE_ASSERT_NEXT(a_accept_acts, start && !busy, busy || strobe, "command dropped")
  `ORLE_ASSERT_SAME(a_more_busy, strobe && !last, busy, "idle before the final beat")
  `ORLE_ASSERT_SAME(a_one_write, we && st == orle_pkg::S_PUT, total < CNT_W'(CAPACITY),
    "insert into a full list")

endmodule
